// ===== rtl/rvl_pkg.sv =====
// rvl_pkg: shared types and constants of the recent value lru list
// depends on nothing; imported by the interfaces and all rtl modules
`default_nettype none

package rvl_pkg;

   // fixed field widths of the items
   localparam int VALUE_W   = 6;
   localparam int SLOT_W    = 4;
   localparam int RECENCY_W = 4;

   // sequencer states
   typedef enum logic {
      SEQ_IDLE,
      SEQ_EMIT
   } rvl_state_type;

   // handshake and step control from the sequencer
   typedef struct packed {
      logic req_ready;
      logic rsp_valid;
      logic update;
      logic rotate;
      logic last;
   } rvl_flow_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic               update;
      logic               rotate;
      logic               miss;
      logic               remove_low;
      logic [VALUE_W-1:0] value;
   } rvl_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/rvl_req_if.sv =====
// rvl_req_if: request channel carrying one value per item
// depends on rvl_pkg
`default_nettype none

interface rvl_req_if import rvl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rvl_rsp_if.sv =====
// rvl_rsp_if: response channel carrying one list entry per item
// depends on rvl_pkg
`default_nettype none

interface rvl_rsp_if import rvl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SLOT_W-1:0]    slot;
   logic [VALUE_W-1:0]   entry_value;
   logic [RECENCY_W-1:0] recency;
   logic                 last;

   modport source (output valid, output slot, output entry_value, output recency,
                   output last, input ready);
   modport sink   (input valid, input slot, input entry_value, input recency,
                   input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/rvl_cell.sv =====
// rvl_cell: one list position holding a value and its lru rank
// depends on rvl_pkg; instantiated in a row by recent_value_lru_list_top
`default_nettype none

module rvl_cell import rvl_pkg::*; #(
   parameter int                  RANK_W      = 4,
   parameter logic [VALUE_W-1:0]  RESET_VALUE = '0,
   parameter logic [RANK_W-1:0]   RESET_RANK  = '0,
   parameter logic [RANK_W-1:0]   OLDEST_RANK = '1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rvl_ctrl_type       ctrl,
   input  wire logic [VALUE_W-1:0] removed_value,
   input  wire logic [RANK_W-1:0]  hit_rank,
   input  wire logic [VALUE_W-1:0] prev_value,
   input  wire logic [RANK_W-1:0]  prev_rank,
   input  wire logic               prev_below,
   input  wire logic [VALUE_W-1:0] next_value,
   input  wire logic [RANK_W-1:0]  next_rank,
   input  wire logic               next_below,
   output logic [VALUE_W-1:0]      value,
   output logic [RANK_W-1:0]       rank,
   output logic                    below,
   output logic                    match,
   output logic                    oldest
);

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic               at_or_above_removed;

   // local compares against the broadcast value
   assign below               = value_ff < ctrl.value;
   assign match               = value_ff == ctrl.value;
   assign oldest              = rank_ff == OLDEST_RANK;
   assign at_or_above_removed = value_ff >= removed_value;

   // next contents from own state, neighbors or the new value
   always_comb begin
      value_in = value_ff;
      rank_in  = rank_ff;
      if (ctrl.rotate) begin
         value_in = next_value;
         rank_in  = next_rank;
      end else if (ctrl.update) begin
         if (!ctrl.miss) begin
            // hit: move to front, younger entries age by one
            if (match) begin
               rank_in = '0;
            end else if (rank_ff < hit_rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end else if (ctrl.remove_low) begin
            // removed entry lies below the insert point: close gap leftward
            if (!at_or_above_removed) begin
               rank_in = rank_ff + 1'b1;
            end else if (next_below) begin
               value_in = next_value;
               rank_in  = next_rank + 1'b1;
            end else if (below) begin
               value_in = ctrl.value;
               rank_in  = '0;
            end else begin
               rank_in = rank_ff + 1'b1;
            end
         end else begin
            // removed entry lies above the insert point: open gap rightward
            if (below) begin
               rank_in = rank_ff + 1'b1;
            end else if (prev_below) begin
               value_in = ctrl.value;
               rank_in  = '0;
            end else if (at_or_above_removed == 1'b0 || value_ff == removed_value) begin
               value_in = prev_value;
               rank_in  = prev_rank + 1'b1;
            end else begin
               rank_in = rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= RESET_VALUE;
         rank_ff  <= RESET_RANK;
      end else begin
         value_ff <= value_in;
         rank_ff  <= rank_in;
      end
   end

   assign value = value_ff;
   assign rank  = rank_ff;

endmodule

`default_nettype wire

// ===== rtl/rvl_seq.sv =====
// rvl_seq: sequencer for update and read-out of the cell row
// depends on rvl_pkg; instantiated by recent_value_lru_list_top
`default_nettype none

module rvl_seq import rvl_pkg::*; #(
   parameter int ENTRIES = 12,
   parameter int IDX_W   = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             rsp_ready,
   output rvl_flow_type          flow,
   output logic [IDX_W-1:0]      slot_count
);

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

   rvl_state_type          state_ff, state_in;
   logic [IDX_W-1:0]       count_ff, count_in;
   logic                   last_slot;

   assign last_slot = count_ff == LAST_SLOT;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) state_in = SEQ_EMIT;
         end
         SEQ_EMIT: begin
            if (rsp_ready && last_slot) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      flow = '0;
      case (state_ff)
         SEQ_IDLE: begin
            flow.req_ready = 1'b1;
            flow.update    = req_valid;
         end
         SEQ_EMIT: begin
            flow.rsp_valid = 1'b1;
            flow.rotate    = rsp_ready;
            flow.last      = last_slot;
         end
         default: flow = '0;
      endcase
   end

   // slot counter, advances on each delivered item
   always_comb begin
      count_in = count_ff;
      if (flow.update) begin
         count_in = '0;
      end else if (flow.rotate) begin
         count_in = last_slot ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign slot_count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/recent_value_lru_list_top.sv =====
// Recent value LRU list. Holds ENTRIES distinct 6-bit values sorted by value, each with
// an lru rank (0 newest). A request value that is present moves to rank 0; an absent
// value replaces the oldest entry and is slotted into sorted position by one shift of
// the cell row, in the cycle the request is accepted. The block then sends ENTRIES
// response items in ascending value order, rotating the row one cell per delivered
// item, and takes the next request after the last one. After reset the list holds
// values 1 .. ENTRIES with ranks 0 .. ENTRIES-1; slot and recency are reported in
// their low 4 bits.
// depends on rvl_pkg, rvl_req_if, rvl_rsp_if, rvl_cell, rvl_seq
`default_nettype none

module recent_value_lru_list_top import rvl_pkg::*; #(
   parameter int ENTRIES = 12
) (
   input  wire logic clock,
   input  wire logic reset,
   rvl_req_if.sink   req_ch,
   rvl_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] OLDEST = IDX_W'(ENTRIES - 1);

   rvl_flow_type        flow;
   rvl_ctrl_type        ctrl;
   logic [IDX_W-1:0]    slot_count;
   logic [VALUE_W-1:0]  cell_value [ENTRIES];
   logic [IDX_W-1:0]    cell_rank  [ENTRIES];
   logic                cell_below [ENTRIES];
   logic [ENTRIES-1:0]  cell_match;
   logic [ENTRIES-1:0]  cell_oldest;
   logic [VALUE_W-1:0]  removed_value;
   logic [IDX_W-1:0]    hit_rank;
   logic [7:0]          slot_wide;
   logic [7:0]          recency_wide;

   rvl_seq #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .flow       (flow),
      .slot_count (slot_count)
   );

   // pick the oldest value and the hit rank from the one-hot cell flags
   always_comb begin
      removed_value = '0;
      hit_rank      = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         removed_value = removed_value | (cell_value[i] & {VALUE_W{cell_oldest[i]}});
         hit_rank      = hit_rank | (cell_rank[i] & {IDX_W{cell_match[i]}});
      end
   end

   // command broadcast to the row
   always_comb begin
      ctrl.update     = flow.update;
      ctrl.rotate     = flow.rotate;
      ctrl.miss       = ~|cell_match;
      ctrl.remove_low = removed_value < req_ch.value;
      ctrl.value      = req_ch.value;
   end

   // row of cells, cell 0 holds the lowest value
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      localparam int PREV = (i == 0) ? 0 : i - 1;
      localparam int NEXT = (i == ENTRIES - 1) ? 0 : i + 1;

      rvl_cell #(
         .RANK_W      (IDX_W),
         .RESET_VALUE (VALUE_W'(i + 1)),
         .RESET_RANK  (IDX_W'(i)),
         .OLDEST_RANK (OLDEST)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .removed_value (removed_value),
         .hit_rank      (hit_rank),
         .prev_value    (cell_value[PREV]),
         .prev_rank     (cell_rank[PREV]),
         .prev_below    ((i == 0) ? 1'b1 : cell_below[PREV]),
         .next_value    (cell_value[NEXT]),
         .next_rank     (cell_rank[NEXT]),
         .next_below    ((i == ENTRIES - 1) ? 1'b0 : cell_below[NEXT]),
         .value         (cell_value[i]),
         .rank          (cell_rank[i]),
         .below         (cell_below[i]),
         .match         (cell_match[i]),
         .oldest        (cell_oldest[i])
      );
   end

   // ports: cell 0 is the item on offer
   assign slot_wide    = 8'(slot_count);
   assign recency_wide = 8'(cell_rank[0]);

   assign req_ch.ready       = flow.req_ready;
   assign rsp_ch.valid       = flow.rsp_valid;
   assign rsp_ch.slot        = slot_wide[SLOT_W-1:0];
   assign rsp_ch.entry_value = cell_value[0];
   assign rsp_ch.recency     = recency_wide[RECENCY_W-1:0];
   assign rsp_ch.last        = flow.last;

endmodule

`default_nettype wire

// ===== rtl/rvl_checker.sv =====
// rvl_checker: port-level checks of the recent value lru list, bound to the top level
// depends on rvl_pkg and recent_value_lru_list_top
`default_nettype none

module rvl_checker import rvl_pkg::*; #(
   parameter int ENTRIES = 12
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [SLOT_W-1:0]    slot,
   input wire logic [VALUE_W-1:0]   entry_value,
   input wire logic                 last
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

   // read-out starts at slot 0 right after an item is taken
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && slot == '0)
      else $error("read-out did not start at slot 0");

   // slots advance by one per delivered item
   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=> rsp_valid && slot == $past(slot) + 1'b1)
      else $error("slot did not advance by one");

   // values are delivered in strictly ascending order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=> entry_value > $past(entry_value))
      else $error("entries not in ascending order");

   // last flag only on the final slot
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last |-> slot == LAST_SLOT)
      else $error("last flag on wrong slot");

   // stalled item holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_value) && $stable(slot))
      else $error("stalled item changed");

endmodule

bind recent_value_lru_list_top rvl_checker #(
   .ENTRIES (ENTRIES)
) u_rvl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .slot        (rsp_ch.slot),
   .entry_value (rsp_ch.entry_value),
   .last        (rsp_ch.last)
);

`default_nettype wire
